// ===== src/lru_slot_binder_top_assert.svh =====
// Assertion helpers used by the binder's back end.
`ifndef LRU_SLOT_BINDER_TOP_ASSERT_SVH
`define LRU_SLOT_BINDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lsb_pkg.sv =====
`default_nettype none
package lsb_pkg;

  // Request modes
  localparam logic [2:0] MODE_AUTO    = 3'd0;
  localparam logic [2:0] MODE_BIND    = 3'd1;
  localparam logic [2:0] MODE_REMOVE  = 3'd2;
  localparam logic [2:0] MODE_RESERVE = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_REM1,
    ST_REM2,
    ST_ADD,
    ST_OUT
  } state_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] object_id;
    logic [4:0] slot_index;
    logic       bad;
  } item_t;

endpackage
`default_nettype wire

// ===== src/lsb_front.sv =====
`default_nettype none
module lsb_front #(
  parameter int SLOT_COUNT   = 16,
  parameter int OBJECT_COUNT = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    in_mode,
  input  wire logic [7:0]    in_object_id,
  input  wire logic [4:0]    in_slot_index,
  input  wire logic          q_full,
  output logic               push,
  output lsb_pkg::item_t     push_data
);

  logic           stage_vld_r, stage_vld_nxt;
  lsb_pkg::item_t stage_r, stage_nxt;
  logic           id_ok, slot_ok, bad, accept;

  // Range checks on the request fields
  assign id_ok   = 13'(in_object_id) < 13'(OBJECT_COUNT);
  assign slot_ok = 6'(in_slot_index) < 6'(SLOT_COUNT);

  // Flag requests that must change nothing
  always_comb begin
    unique case (in_mode)
      lsb_pkg::MODE_AUTO,
      lsb_pkg::MODE_REMOVE:  bad = !id_ok;
      lsb_pkg::MODE_BIND:    bad = !id_ok || !slot_ok;
      lsb_pkg::MODE_RESERVE,
      lsb_pkg::MODE_RELEASE: bad = !slot_ok;
      default:               bad = 1'b1;
    endcase
  end

  // Hold off new transactions only while the stage is stuck behind a full queue
  assign busy      = stage_vld_r && q_full;
  assign accept    = start && !busy;
  assign push      = stage_vld_r && !q_full;
  assign push_data = stage_r;

  // Advance the classify stage
  always_comb begin
    stage_nxt     = stage_r;
    stage_vld_nxt = stage_vld_r;
    if (accept) begin
      stage_vld_nxt        = 1'b1;
      stage_nxt.mode       = in_mode;
      stage_nxt.object_id  = in_object_id;
      stage_nxt.slot_index = in_slot_index;
      stage_nxt.bad        = bad;
    end else if (push) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

endmodule
`default_nettype wire

// ===== src/lsb_queue.sv =====
`default_nettype none
module lsb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lsb_pkg::item_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output lsb_pkg::item_t      head
);

  lsb_pkg::item_t mem_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rptr_r];

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lsb_back.sv =====
`default_nettype none
`include "lru_slot_binder_top_assert.svh"
module lsb_back #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lsb_pkg::item_t head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [3:0]          out_bound_slot,
  output logic                out_evicted_valid,
  output logic [7:0]          out_evicted_id
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  lsb_pkg::state_t state_r, state_nxt;

  // Slot table and recency list
  logic [7:0]            owner_r   [SLOT_COUNT];
  logic [7:0]            owner_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [SLOT_COUNT-1:0] res_r, res_nxt;
  logic [SW-1:0]         order_r   [SLOT_COUNT];
  logic [SW-1:0]         order_nxt [SLOT_COUNT];
  logic [CW-1:0]         cnt_r, cnt_nxt;

  // List operations planned during lookup
  logic          rem1_vld_r, rem1_vld_nxt, rem2_vld_r, rem2_vld_nxt, add_vld_r, add_vld_nxt;
  logic [SW-1:0] rem1_slot_r, rem1_slot_nxt, rem2_slot_r, rem2_slot_nxt;
  logic [SW-1:0] add_slot_r, add_slot_nxt;

  // Result registers
  logic [1:0]    status_r, status_nxt;
  logic [SW-1:0] bslot_r, bslot_nxt;
  logic          ev_r, ev_nxt;
  logic [7:0]    evid_r, evid_nxt;

  // Lookup results
  logic          hit_any, free_any, vic_any;
  logic [SW-1:0] hit_slot, free_slot, vic_slot, rq;

  // Removal shift control
  logic [SW-1:0]         op_slot;
  logic [SLOT_COUNT-1:0] shift;
  logic                  rem_hit;

  assign rq = head.slot_index[SW-1:0];

  // Search slot table and recency list; lowest index wins
  always_comb begin
    hit_any   = 1'b0;
    hit_slot  = '0;
    free_any  = 1'b0;
    free_slot = '0;
    vic_any   = 1'b0;
    vic_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (occ_r[i] && owner_r[i] == head.object_id) begin
        hit_any  = 1'b1;
        hit_slot = SW'(i);
      end
      if (!occ_r[i] && !res_r[i]) begin
        free_any  = 1'b1;
        free_slot = SW'(i);
      end
      if (CW'(i) < cnt_r && !res_r[order_r[i]]) begin
        vic_any  = 1'b1;
        vic_slot = order_r[i];
      end
    end
  end

  // Mark list positions at and after the removed slot
  always_comb begin
    op_slot = (state_r == lsb_pkg::ST_REM1) ? rem1_slot_r : rem2_slot_r;
    rem_hit = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (CW'(j) < cnt_r && order_r[j] == op_slot) begin
        rem_hit = 1'b1;
      end
      shift[j] = rem_hit;
    end
  end

  // Sequence lookup, list edits and result
  always_comb begin
    state_nxt     = state_r;
    owner_nxt     = owner_r;
    occ_nxt       = occ_r;
    res_nxt       = res_r;
    order_nxt     = order_r;
    cnt_nxt       = cnt_r;
    rem1_vld_nxt  = rem1_vld_r;
    rem1_slot_nxt = rem1_slot_r;
    rem2_vld_nxt  = rem2_vld_r;
    rem2_slot_nxt = rem2_slot_r;
    add_vld_nxt   = add_vld_r;
    add_slot_nxt  = add_slot_r;
    status_nxt    = status_r;
    bslot_nxt     = bslot_r;
    ev_nxt        = ev_r;
    evid_nxt      = evid_r;
    pop           = 1'b0;
    unique case (state_r)
      lsb_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = lsb_pkg::ST_LOOK;
        end
      end
      lsb_pkg::ST_LOOK: begin
        rem1_vld_nxt  = 1'b0;
        rem1_slot_nxt = '0;
        rem2_vld_nxt  = 1'b0;
        rem2_slot_nxt = '0;
        add_vld_nxt   = 1'b0;
        add_slot_nxt  = '0;
        status_nxt    = lsb_pkg::STATUS_OK;
        bslot_nxt     = '0;
        ev_nxt        = 1'b0;
        evid_nxt      = '0;
        if (head.bad) begin
          status_nxt = lsb_pkg::STATUS_BAD;
        end else begin
          unique case (head.mode)
            lsb_pkg::MODE_AUTO: begin
              priority if (hit_any) begin
                // refresh recency
                rem1_vld_nxt  = 1'b1;
                rem1_slot_nxt = hit_slot;
                add_vld_nxt   = 1'b1;
                add_slot_nxt  = hit_slot;
                bslot_nxt     = hit_slot;
              end else if (free_any) begin
                occ_nxt[free_slot]   = 1'b1;
                owner_nxt[free_slot] = head.object_id;
                add_vld_nxt          = 1'b1;
                add_slot_nxt         = free_slot;
                bslot_nxt            = free_slot;
              end else if (vic_any) begin
                ev_nxt              = 1'b1;
                evid_nxt            = owner_r[vic_slot];
                owner_nxt[vic_slot] = head.object_id;
                rem1_vld_nxt        = 1'b1;
                rem1_slot_nxt       = vic_slot;
                add_vld_nxt         = 1'b1;
                add_slot_nxt        = vic_slot;
                bslot_nxt           = vic_slot;
              end else begin
                status_nxt = lsb_pkg::STATUS_FULL;
              end
            end
            lsb_pkg::MODE_BIND: begin
              // drop the old binding, evict the target occupant
              if (hit_any) begin
                occ_nxt[hit_slot] = 1'b0;
                rem1_vld_nxt      = 1'b1;
                rem1_slot_nxt     = hit_slot;
              end
              if (occ_r[rq] && !(hit_any && hit_slot == rq)) begin
                ev_nxt        = 1'b1;
                evid_nxt      = owner_r[rq];
                rem2_vld_nxt  = 1'b1;
                rem2_slot_nxt = rq;
              end
              occ_nxt[rq]   = 1'b1;
              owner_nxt[rq] = head.object_id;
              add_vld_nxt   = 1'b1;
              add_slot_nxt  = rq;
              bslot_nxt     = rq;
            end
            lsb_pkg::MODE_REMOVE: begin
              if (hit_any) begin
                occ_nxt[hit_slot] = 1'b0;
                rem1_vld_nxt      = 1'b1;
                rem1_slot_nxt     = hit_slot;
              end
            end
            lsb_pkg::MODE_RESERVE: begin
              if (occ_r[rq]) begin
                ev_nxt        = 1'b1;
                evid_nxt      = owner_r[rq];
                occ_nxt[rq]   = 1'b0;
                rem1_vld_nxt  = 1'b1;
                rem1_slot_nxt = rq;
              end
              res_nxt[rq] = 1'b1;
            end
            lsb_pkg::MODE_RELEASE: begin
              res_nxt[rq] = 1'b0;
            end
            default: begin
              status_nxt = lsb_pkg::STATUS_BAD;
            end
          endcase
        end
        state_nxt = lsb_pkg::ST_REM1;
      end
      lsb_pkg::ST_REM1,
      lsb_pkg::ST_REM2: begin
        // close the gap left by the removed slot
        if (((state_r == lsb_pkg::ST_REM1) ? rem1_vld_r : rem2_vld_r) && rem_hit) begin
          for (int j = 0; j < SLOT_COUNT - 1; j++) begin
            order_nxt[j] = shift[j] ? order_r[j+1] : order_r[j];
          end
          cnt_nxt = cnt_r - CW'(1);
        end
        state_nxt = (state_r == lsb_pkg::ST_REM1) ? lsb_pkg::ST_REM2 : lsb_pkg::ST_ADD;
      end
      lsb_pkg::ST_ADD: begin
        // append as most recently used
        if (add_vld_r && cnt_r < CW'(SLOT_COUNT)) begin
          order_nxt[cnt_r[SW-1:0]] = add_slot_r;
          cnt_nxt                  = cnt_r + CW'(1);
        end
        state_nxt = lsb_pkg::ST_OUT;
      end
      lsb_pkg::ST_OUT: begin
        pop       = 1'b1;
        state_nxt = lsb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lsb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = state_r == lsb_pkg::ST_OUT;
  assign out_status        = status_r;
  assign out_bound_slot    = 4'(bslot_r);
  assign out_evicted_valid = ev_r;
  assign out_evicted_id    = evid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsb_pkg::ST_IDLE;
      occ_r   <= '0;
      res_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      res_r   <= res_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    owner_r     <= owner_nxt;
    order_r     <= order_nxt;
    rem1_vld_r  <= rem1_vld_nxt;
    rem1_slot_r <= rem1_slot_nxt;
    rem2_vld_r  <= rem2_vld_nxt;
    rem2_slot_r <= rem2_slot_nxt;
    add_vld_r   <= add_vld_nxt;
    add_slot_r  <= add_slot_nxt;
    status_r    <= status_nxt;
    bslot_r     <= bslot_nxt;
    ev_r        <= ev_nxt;
    evid_r      <= evid_nxt;
  end

  `LSB_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(SLOT_COUNT), "list overflow")
  `LSB_ASSERT_NOW(a_cnt_occ, clk, rst_n, state_r == lsb_pkg::ST_IDLE, $countones(occ_r) == int'(cnt_r), "list out of sync with occupancy")
  `LSB_ASSERT_NEXT(a_out_pulse, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `LSB_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, !q_empty, "pop from empty queue")

endmodule
`default_nettype wire

// ===== src/lru_slot_binder_top.sv =====
`default_nettype none
// LRU slot binder: maps object ids onto SLOT_COUNT slots with LRU replacement.
// Input channel: drive in_mode, in_object_id, in_slot_index with start; the
// transaction is taken on a rising edge where start is high and busy is low.
// Modes: auto bind, bind to slot, remove, reserve slot, release slot.
// Result channel: out_valid pulses for one cycle with out_status,
// out_bound_slot, out_evicted_valid and out_evicted_id. The receiver cannot
// stall; each result is taken in the cycle it is shown.
// An accepted transaction is registered in the classify stage, then in the
// queue, and is then worked by the back-end sequencer (idle check, lookup,
// two list removals, append, result), one transaction at a time. The queue
// head is the transaction in progress; the queue and the classify stage hold
// up to two more behind it before busy rises.
// Reset (rst_n low, synchronous) clears all bindings, reservations and the
// recency list; no clearing pass is needed.
module lru_slot_binder_top #(
  parameter int SLOT_COUNT   = 16,
  parameter int OBJECT_COUNT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_object_id,
  input  wire logic [4:0] in_slot_index,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [3:0]      out_bound_slot,
  output logic            out_evicted_valid,
  output logic [7:0]      out_evicted_id
);

  lsb_pkg::item_t push_data, head;
  logic           push, pop, q_full, q_empty;

  lsb_front #(
    .SLOT_COUNT  (SLOT_COUNT),
    .OBJECT_COUNT(OBJECT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_object_id (in_object_id),
    .in_slot_index(in_slot_index),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  lsb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  lsb_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_bound_slot   (out_bound_slot),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_id   (out_evicted_id)
  );

endmodule
`default_nettype wire
